@@ rtl/best_fit_block_allocator_top_macros.svh @@
// Assertion macros for the allocator
`ifndef BEST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define BFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFA_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFA_ASSERT(label, clk, rst_n, prop, msg)
`define BFA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ rtl/bfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;
    localparam int MAX_REGIONS = 64;
    localparam int RAM_BLOCKS  = 16384;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam logic [15:0] FIT_LIMIT  = 16'hFFFF;
    localparam logic [15:0] RAM_SIZE16 = 16'(RAM_BLOCKS);

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_RESIZE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,      // issue read of entry r_i
        S_CHK,     // evaluate entry r_i
        S_SHL,     // remove: copy entry i+1 to i
        S_SHR,     // insert: copy entry i-1 to i
        S_WR,      // single-entry write
        S_SUM,     // unused; the sum pass runs in phase P_SUM
        S_OUT
    } t_state;

    // phases of a command
    typedef enum logic [2:0] {
        P_ALLOC, P_FNEXT, P_FPREV, P_FINS, P_RESIZE, P_SUM
    } t_phase;
endpackage
`default_nettype wire

@@ rtl/best_fit_block_allocator_top.sv @@
// Best-fit block allocator. Accepts one command beat (allocate, free, resize)
// at a time and returns one result beat. The region table lives in one
// synchronous memory of MAX_REGIONS (address, size) pairs, one read and one
// write per cycle. A command scans the stored regions, shifts entries for
// insert or removal, and ends with a pass that totals the free blocks. A
// finished result waits in the output register; the next command is taken
// once it has left.
`timescale 1ns / 1ps
`default_nettype none
`include "best_fit_block_allocator_top_macros.svh"
module best_fit_block_allocator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [15:0] i_address,
    input  wire logic [15:0] i_size,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_address_res,
    output logic [15:0]      o_free_blocks,
    output logic [6:0]       o_region_count
);
    localparam int IW = bfa_pkg::IDX_W;
    localparam int CW = bfa_pkg::CNT_W;

    logic [31:0] mem [bfa_pkg::MAX_REGIONS];
    logic [31:0] r_rd;
    logic        mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    logic [31:0] mem_wd;

    bfa_pkg::t_state r_st, n_st;
    bfa_pkg::t_phase r_ph, n_ph;
    logic [CW-1:0] r_tot, n_tot;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;        // target entry
    logic        r_done, n_done;
    logic        r_rm, n_rm;        // marks the best-fit cut pass, or a shift-left removal after a merge
    logic [15:0] r_ptr, r_len, n_len;
    logic [16:0] r_best, n_best;
    logic        r_hit, n_hit;
    logic [31:0] r_wval, n_wval;
    logic        r_carry, n_carry;
    logic [15:0] r_sum, n_sum;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_res, n_res;
    logic        r_init;
    logic [15:0] r_ov_fb, r_ov_res;
    logic [1:0]  r_ov_st;
    logic [6:0]  r_ov_rc;
    logic        r_ov;

    // memory with registered read; seed entry 0 with the whole RAM at reset
    always_ff @(posedge i_clk) begin
        if (r_init) mem[0] <= {16'd0, bfa_pkg::RAM_SIZE16};
        else if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    logic [15:0] e_a, e_s;
    logic [16:0] e_end;
    logic [15:0] nxt;
    assign e_a   = r_rd[31:16];
    assign e_s   = r_rd[15:0];
    assign e_end = {1'b0, e_a} + {1'b0, e_s};
    assign nxt   = r_ptr + r_len;

    logic accept;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_st != bfa_pkg::S_IDLE) || (r_ov && i_stall) || r_init;

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_tot = r_tot; n_i = r_i; n_j = r_j;
        n_done = r_done; n_rm = r_rm; n_len = r_len; n_best = r_best;
        n_hit = r_hit; n_wval = r_wval; n_carry = r_carry; n_sum = r_sum;
        n_status = r_status; n_res = r_res;
        mem_we = 1'b0; mem_wa = r_i[IW-1:0]; mem_wd = r_wval;
        mem_ra = r_i[IW-1:0];
        unique case (r_st)
            bfa_pkg::S_IDLE: begin
                if (accept) begin
                    n_i = '0; n_done = 1'b0; n_rm = 1'b0; n_hit = 1'b0;
                    n_best = {1'b0, bfa_pkg::FIT_LIMIT}; n_status = bfa_pkg::ST_OK;
                    n_res = '0; n_sum = '0;
                    n_len = (i_size == 16'd0) ? 16'd1 : i_size;
                    n_st = bfa_pkg::S_RD;
                    unique case (bfa_pkg::t_cmd'(i_cmd))
                        bfa_pkg::CMD_ALLOC:  n_ph = bfa_pkg::P_ALLOC;
                        bfa_pkg::CMD_FREE:   n_ph = bfa_pkg::P_FNEXT;
                        bfa_pkg::CMD_RESIZE: begin
                            n_ph = bfa_pkg::P_RESIZE; n_len = i_size;
                            if (r_tot == '0) begin
                                n_status = bfa_pkg::ST_OOM; n_ph = bfa_pkg::P_SUM;
                            end else n_i = r_tot - 1'b1;
                        end
                        default: n_ph = bfa_pkg::P_SUM;
                    endcase
                end
            end
            bfa_pkg::S_RD: begin
                if (r_i >= r_tot) begin
                    // end of scan
                    unique case (r_ph)
                        bfa_pkg::P_ALLOC: begin
                            if (!r_hit) begin
                                n_status = bfa_pkg::ST_OOM; n_ph = bfa_pkg::P_SUM;
                                n_i = '0;
                            end else begin
                                n_i = r_j; n_st = bfa_pkg::S_RD; n_rm = 1'b1;
                            end
                        end
                        bfa_pkg::P_FNEXT: begin n_ph = bfa_pkg::P_FPREV; n_i = '0; end
                        bfa_pkg::P_FPREV: begin
                            n_i = '0;
                            if (r_done) n_ph = bfa_pkg::P_SUM;
                            else if (r_tot >= CW'(bfa_pkg::MAX_REGIONS)) begin
                                n_status = bfa_pkg::ST_FULL; n_ph = bfa_pkg::P_SUM;
                            end else n_ph = bfa_pkg::P_FINS;
                        end
                        bfa_pkg::P_FINS: begin
                            // append at end
                            n_wval = {r_ptr, r_len}; n_j = r_tot;
                            n_st = bfa_pkg::S_WR; n_i = r_tot;
                            n_tot = r_tot + 1'b1;
                        end
                        bfa_pkg::P_SUM: n_st = bfa_pkg::S_OUT;
                        default: n_st = bfa_pkg::S_CHK;
                    endcase
                end else n_st = bfa_pkg::S_CHK;
            end
            bfa_pkg::S_CHK: begin
                n_st = bfa_pkg::S_RD; n_i = r_i + 1'b1;
                unique case (r_ph)
                    bfa_pkg::P_ALLOC: begin
                        if (r_rm) begin
                            // best region: cut from front
                            n_res = e_a;
                            n_wval = {e_a + r_len, e_s - r_len};
                            n_st = bfa_pkg::S_WR; n_i = r_i;
                        end else if (e_s == r_len) begin
                            n_res = e_a; n_j = r_i;
                            n_st = bfa_pkg::S_SHL; n_i = r_i;
                            n_tot = r_tot - 1'b1;
                        end else if (e_s > r_len && {1'b0, e_s} < r_best) begin
                            n_best = {1'b0, e_s}; n_j = r_i; n_hit = 1'b1;
                        end
                    end
                    bfa_pkg::P_FNEXT: begin
                        if (e_a > nxt) begin
                            n_ph = bfa_pkg::P_FPREV; n_i = '0;
                        end else if (e_a == nxt) begin
                            n_wval = {r_ptr, e_s + r_len};
                            n_len = e_s + r_len; n_j = r_i; n_done = 1'b1;
                            n_st = bfa_pkg::S_WR; n_i = r_i;
                        end
                    end
                    bfa_pkg::P_FPREV: begin
                        if (e_end > {1'b0, r_ptr}) begin
                            n_i = r_tot;
                        end else if (e_end == {1'b0, r_ptr}) begin
                            n_wval = {e_a, e_s + r_len};
                            n_st = bfa_pkg::S_WR; n_i = r_i;
                            if (r_done) n_rm = 1'b1;
                            n_done = 1'b1;
                        end
                    end
                    bfa_pkg::P_FINS: begin
                        if (e_a >= r_ptr) begin
                            // shift right from the end down to r_i
                            n_j = r_i; n_i = r_tot; n_tot = r_tot + 1'b1;
                            n_wval = {r_ptr, r_len};
                            n_st = bfa_pkg::S_SHR;
                        end
                    end
                    bfa_pkg::P_RESIZE: begin : rsz
                        logic [15:0] cur, nsz;
                        cur = bfa_pkg::RAM_SIZE16 - e_a - e_s;
                        nsz = e_s;
                        if (r_len > cur) begin
                            if ({1'b0, r_len} - {1'b0, cur} > {1'b0, e_s})
                                n_status = bfa_pkg::ST_OOM;
                            else nsz = e_s - (r_len - cur);
                        end else nsz = e_s + (cur - r_len);
                        n_i = '0; n_ph = bfa_pkg::P_SUM;
                        if (n_status == bfa_pkg::ST_OK) begin
                            n_res = e_a + nsz; n_wval = {e_a, nsz};
                            n_st = bfa_pkg::S_WR; n_i = r_i;
                        end
                    end
                    bfa_pkg::P_SUM: n_sum = r_sum + e_s;
                    default: ;
                endcase
            end
            bfa_pkg::S_WR: begin
                mem_we = 1'b1; mem_wa = r_i[IW-1:0]; mem_wd = r_wval;
                n_i = '0; n_st = bfa_pkg::S_RD;
                unique case (r_ph)
                    bfa_pkg::P_FNEXT: n_ph = bfa_pkg::P_FPREV;
                    bfa_pkg::P_FPREV: begin
                        if (r_rm) begin
                            n_i = r_j; n_st = bfa_pkg::S_SHL; n_tot = r_tot - 1'b1;
                        end else n_ph = bfa_pkg::P_SUM;
                    end
                    default: n_ph = bfa_pkg::P_SUM;
                endcase
            end
            bfa_pkg::S_SHL: begin
                // read i+1 then write it to i
                if (r_i >= r_tot) begin
                    n_i = '0; n_ph = bfa_pkg::P_SUM; n_st = bfa_pkg::S_RD;
                end else begin
                    mem_ra = IW'(r_i + 1'b1);
                    n_carry = ~r_carry;
                    if (r_carry) begin
                        mem_we = 1'b1; mem_wd = r_rd; mem_wa = r_i[IW-1:0];
                        n_i = r_i + 1'b1;
                    end
                end
            end
            bfa_pkg::S_SHR: begin
                if (r_i == r_j) begin
                    mem_we = 1'b1; mem_wd = r_wval;
                    n_i = '0; n_ph = bfa_pkg::P_SUM; n_st = bfa_pkg::S_RD;
                end else begin
                    mem_ra = IW'(r_i - 1'b1);
                    n_carry = ~r_carry;
                    if (r_carry) begin
                        mem_we = 1'b1; mem_wd = r_rd;
                        n_i = r_i - 1'b1;
                    end
                end
            end
            bfa_pkg::S_OUT: begin
                if (!(r_ov && i_stall)) n_st = bfa_pkg::S_IDLE;
            end
            default: n_st = bfa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bfa_pkg::S_IDLE; r_tot <= CW'(1); r_init <= 1'b1;
            r_ov <= 1'b0; r_carry <= 1'b0; r_ph <= bfa_pkg::P_SUM;
        end else begin
            r_st <= n_st; r_tot <= n_tot; r_ph <= n_ph;
            r_carry <= (n_st == r_st) ? n_carry : 1'b0;
            r_init <= 1'b0;
            if (r_st == bfa_pkg::S_OUT && !(r_ov && i_stall)) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_done <= n_done; r_rm <= n_rm; r_len <= n_len;
        r_best <= n_best; r_hit <= n_hit; r_wval <= n_wval; r_sum <= n_sum;
        r_status <= n_status; r_res <= n_res;
        if (accept) r_ptr <= i_address;
        if (r_st == bfa_pkg::S_OUT && !(r_ov && i_stall)) begin
            r_ov_st  <= r_status;
            r_ov_res <= (r_status == bfa_pkg::ST_OK) ? r_res : 16'd0;
            r_ov_fb  <= r_sum;
            r_ov_rc  <= 7'(r_tot);
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_ov_st;
    assign o_address_res  = r_ov_res;
    assign o_free_blocks  = r_ov_fb;
    assign o_region_count = r_ov_rc;

    `BFA_ASSERT(a_tot_range, i_clk, i_rst_n, r_tot <= CW'(bfa_pkg::MAX_REGIONS), "table overflow")
    `BFA_ASSERT(a_busy_stall, i_clk, i_rst_n, (r_st != bfa_pkg::S_IDLE) |-> o_stall, "accept while busy")
    `BFA_ASSERT(a_status_ok, i_clk, i_rst_n, o_valid |-> (o_status != bfa_pkg::ST_RSVD), "bad status")
endmodule
`default_nettype wire
